[design/spq_pkg.sv]
// Shared types, sizes and codes for the sorted priority queue.
// No dependencies; spq_engine and sorted_priority_queue refer to it by scoped names.
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int PRI_W    = 8;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 5;
  localparam int ENTRY_W  = ID_W + PRI_W;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
  } op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [OCC_W-1:0]  occupancy;
  } res_t;

endpackage

[design/spq_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/spq_engine.sv]
// Sequencer of the queue: sorted insert, head pop and delete by ID, each done
// as read-compare-write sweeps over the entry RAM. Uses spq_pkg and spq_ram.
module spq_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  spq_pkg::op_t    op,
  output logic            idle,
  input  logic            res_ready,
  output logic            done,
  output spq_pkg::res_t   res
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ADD_CMP = 3'd1;
  localparam logic [2:0] S_ADD_PUT = 3'd2;
  localparam logic [2:0] S_FIND    = 3'd3;
  localparam logic [2:0] S_DEL     = 3'd4;
  localparam logic [2:0] S_FIN     = 3'd5;

  localparam int CW = spq_pkg::CNT_W;
  localparam int AW = spq_pkg::ADDR_W;

  logic [2:0]    state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] ptr, ptr_next;
  spq_pkg::op_t  op_r, op_r_next;
  logic [spq_pkg::STAT_W-1:0] status_r, status_r_next;
  spq_pkg::entry_t hit, hit_next;

  logic                  we, re;
  logic [CW-1:0]         waddr, raddr;
  spq_pkg::entry_t       wdata, rd;
  logic [spq_pkg::ENTRY_W-1:0] rdata;

  logic [CW-1:0] ptr_inc, ptr_dec, ptr_dec2;
  logic          more;
  logic          match;
  spq_pkg::entry_t new_entry;

  spq_ram #(
    .WIDTH(spq_pkg::ENTRY_W),
    .DEPTH(spq_pkg::CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr[AW-1:0]),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr[AW-1:0]),
    .rdata(rdata)
  );

  assign rd        = spq_pkg::entry_t'(rdata);
  assign ptr_inc   = ptr + CW'(1);
  assign ptr_dec   = ptr - CW'(1);
  assign ptr_dec2  = ptr - CW'(2);
  assign more      = (ptr_inc < count);
  assign match     = (op_r.kind == spq_pkg::KIND_POP) || (rd.id == op_r.id);
  assign new_entry = '{id: op_r.id, pri: op_r.pri};

  always_comb begin
    state_next    = state;
    count_next    = count;
    ptr_next      = ptr;
    op_r_next     = op_r;
    status_r_next = status_r;
    hit_next      = hit;
    we            = 1'b0;
    waddr         = ptr;
    wdata         = new_entry;
    re            = 1'b0;
    raddr         = ptr;
    done          = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          op_r_next     = op;
          status_r_next = spq_pkg::ST_OK;
          hit_next      = '0;
          case (op.kind)
            spq_pkg::KIND_ADD: begin
              if (count == CW'(spq_pkg::CAPACITY)) begin
                status_r_next = spq_pkg::ST_FULL;
                state_next    = S_FIN;
              end else if (count == '0) begin
                // empty list: place the entry at the head directly
                we         = 1'b1;
                waddr      = '0;
                wdata      = '{id: op.id, pri: op.pri};
                count_next = CW'(1);
                state_next = S_FIN;
              end else begin
                ptr_next   = count;
                re         = 1'b1;
                raddr      = count - CW'(1);
                state_next = S_ADD_CMP;
              end
            end
            spq_pkg::KIND_POP, spq_pkg::KIND_REMOVE: begin
              if (count == '0) begin
                status_r_next = spq_pkg::ST_EMPTY;
                state_next    = S_FIN;
              end else begin
                ptr_next   = '0;
                re         = 1'b1;
                raddr      = '0;
                state_next = S_FIND;
              end
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end

      // rd holds entry[ptr-1]; shift it up while it ranks below the new one
      S_ADD_CMP: begin
        if (rd.pri < op_r.pri) begin
          we    = 1'b1;
          waddr = ptr;
          wdata = rd;
          ptr_next = ptr_dec;
          if (ptr == CW'(1)) begin
            state_next = S_ADD_PUT;
          end else begin
            re    = 1'b1;
            raddr = ptr_dec2;
          end
        end else begin
          we         = 1'b1;
          waddr      = ptr;
          count_next = count + CW'(1);
          state_next = S_FIN;
        end
      end

      S_ADD_PUT: begin
        we         = 1'b1;
        waddr      = ptr;
        count_next = count + CW'(1);
        state_next = S_FIN;
      end

      // rd holds entry[ptr]; pop matches the head at once
      S_FIND: begin
        if (match) begin
          if (op_r.kind == spq_pkg::KIND_POP) begin
            hit_next = rd;
          end
          if (more) begin
            re         = 1'b1;
            raddr      = ptr_inc;
            ptr_next   = ptr_inc;
            state_next = S_DEL;
          end else begin
            count_next = count - CW'(1);
            state_next = S_FIN;
          end
        end else if (more) begin
          re       = 1'b1;
          raddr    = ptr_inc;
          ptr_next = ptr_inc;
        end else begin
          status_r_next = spq_pkg::ST_NOT_FOUND;
          state_next    = S_FIN;
        end
      end

      // rd holds entry[ptr]; move it down one slot
      S_DEL: begin
        we    = 1'b1;
        waddr = ptr_dec;
        wdata = rd;
        if (more) begin
          re       = 1'b1;
          raddr    = ptr_inc;
          ptr_next = ptr_inc;
        end else begin
          count_next = count - CW'(1);
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        if (res_ready) begin
          done       = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    ptr      <= ptr_next;
    op_r     <= op_r_next;
    status_r <= status_r_next;
    hit      <= hit_next;
  end

  assign idle          = (state == S_IDLE);
  assign res.status    = status_r;
  assign res.id        = hit.id;
  assign res.pri       = hit.pri;
  assign res.occupancy = spq_pkg::OCC_W'(count);

endmodule

[design/sorted_priority_queue.sv]
// Top level of the sorted priority queue: input handshake and result register.
// Uses spq_pkg and spq_engine (which holds the entry RAM, spq_ram).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation word: kind
//   (add, pop, remove by id), task_id and priority_req. Output channel
//   (out_valid/out_ready) returns exactly one word per operation: status,
//   out_task_id, out_priority (zero unless a pop succeeded) and occupancy.
//   Entries sit in one RAM with a registered read, kept sorted by
//   descending priority, older first among equals.
// Flow: a refused add, an ignored code, a pop or remove on an empty queue, or
//   an add to an empty queue goes straight to the result. An add walks down
//   from the tail, one entry per cycle. Pop and remove scan to the match and
//   then close the gap, one RAM read and write per cycle. in_ready returns in
//   the same cycle as out_valid rises; the single RAM port pair sets the
//   one-entry-per-cycle pace.
// Reset: rst (synchronous) empties the queue at once; RAM contents are kept.
// Stall: a finished result waits in the output register while the next word
//   is taken; the engine then holds its own result until the register frees.
module sorted_priority_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spq_pkg::KIND_W-1:0]   kind,
  input  logic [spq_pkg::ID_W-1:0]     task_id,
  input  logic [spq_pkg::PRI_W-1:0]    priority_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spq_pkg::STAT_W-1:0]   status,
  output logic [spq_pkg::ID_W-1:0]     out_task_id,
  output logic [spq_pkg::PRI_W-1:0]    out_priority,
  output logic [spq_pkg::OCC_W-1:0]    occupancy
);

  spq_pkg::op_t  op;
  spq_pkg::res_t res;
  spq_pkg::res_t res_q;
  logic          eng_idle;
  logic          eng_done;
  logic          start;
  logic          slot_free;

  // take a new word whenever the sequencer is idle
  assign in_ready  = eng_idle;
  assign start     = in_valid && in_ready;
  assign op        = '{kind: kind, id: task_id, pri: priority_req};
  // the output register can take a result when empty or being drained
  assign slot_free = !out_valid || out_ready;

  spq_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .idle     (eng_idle),
    .res_ready(slot_free),
    .done     (eng_done),
    .res      (res)
  );

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (eng_done) begin
      res_q <= res;
    end
  end

  assign status       = res_q.status;
  assign out_task_id  = res_q.id;
  assign out_priority = res_q.pri;
  assign occupancy    = res_q.occupancy;

endmodule

[sim/tb_sorted_priority_queue.sv]
// Self-checking testbench for sorted_priority_queue: drives operation words, predicts each
// result word with a local sorted-list model and compares every field on the output channel.
// Depends on spq_pkg and the design sources under design/.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  // Kind code 3 has no name in the package; the queue ignores it but still answers.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KIND_W-1:0] kind = '0;
  logic [ID_W-1:0]   task_id = '0;
  logic [PRI_W-1:0]  priority_req = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_task_id;
  logic [PRI_W-1:0]  out_priority;
  logic [OCC_W-1:0]  occupancy;

  // Local copy of the queue contents, kept in the same sorted order as the block.
  entry_t model_entries [CAPACITY];
  int     model_count = 0;

  // Result words predicted at accept time, oldest first.
  res_t   expected_words [$];
  res_t   oldest_word;
  int     mismatch_count = 0;

  // Idle knobs read by the sender and the receiver, in percent per cycle.
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  // Long receiver hold-off: a test posts a cycle count, the receiver counts it down.
  int     hold_request = 0;
  int     hold_left = 0;

  // Random traffic alternates between filling and draining bursts.
  bit     fill_mode = 1'b1;
  int     burst_left = 0;

  sorted_priority_queue u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .task_id      (task_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_task_id  (out_task_id),
    .out_priority (out_priority),
    .occupancy    (occupancy)
  );

  always #5 clk = ~clk;

  // Close the gap at pos by shifting the tail down one slot.
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < model_count; i++) begin
      model_entries[i] = model_entries[i + 1];
    end
    model_count--;
  endfunction

  // Apply one operation to the local queue and return the result word it must produce.
  function automatic res_t queue_apply(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                       logic [PRI_W-1:0] pri);
    res_t r;
    int   pos;
    int   hit;
    r = '0;
    r.status = ST_OK;
    case (k)
      KIND_ADD: begin
        if (model_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // Place the new entry after every entry of equal or higher priority.
          pos = 0;
          while (pos < model_count && model_entries[pos].pri >= pri) pos++;
          for (int i = model_count; i > pos; i--) begin
            model_entries[i] = model_entries[i - 1];
          end
          model_entries[pos].id  = id;
          model_entries[pos].pri = pri;
          model_count++;
        end
      end
      KIND_POP: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id  = model_entries[0].id;
          r.pri = model_entries[0].pri;
          drop_entry(0);
        end
      end
      KIND_REMOVE: begin
        if (model_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Only the first match in queue order goes away.
          hit = -1;
          for (int i = 0; i < model_count; i++) begin
            if (hit < 0 && model_entries[i].id == id) hit = i;
          end
          if (hit >= 0) drop_entry(hit);
          else r.status = ST_NOT_FOUND;
        end
      end
      default: begin
        // Unused code: leave the queue alone and just report occupancy.
      end
    endcase
    r.occupancy = OCC_W'(model_count);
    return r;
  endfunction

  // Offer one word and hold it until accepted; predict its result at the accepting edge.
  // Valid stays high afterwards so back-to-back words never drop it within one step.
  task automatic send_word(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic [PRI_W-1:0] pri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    task_id      <= id;
    priority_req <= pri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(queue_apply(k, id, pri));
  endtask

  // Receiver: stall at random, or hold off entirely while a posted count runs down.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: status %0d id %0h pri %0h occ %0d",
               status, out_task_id, out_priority, occupancy);
        mismatch_count++;
      end else begin
        oldest_word = expected_words.pop_front();
        if (status !== oldest_word.status) begin
          $error("status: expected %0d, actual %0d", oldest_word.status, status);
          mismatch_count++;
        end
        if (out_task_id !== oldest_word.id) begin
          $error("out_task_id: expected %0h, actual %0h", oldest_word.id, out_task_id);
          mismatch_count++;
        end
        if (out_priority !== oldest_word.pri) begin
          $error("out_priority: expected %0h, actual %0h", oldest_word.pri, out_priority);
          mismatch_count++;
        end
        if (occupancy !== oldest_word.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", oldest_word.occupancy, occupancy);
          mismatch_count++;
        end
      end
    end
  end

  // Pop, remove and the unused code all on an empty queue.
  task automatic test_empty_queue();
    send_word(KIND_POP, 16'hFFFF, 8'hFF);
    send_word(KIND_REMOVE, 16'h0000, 8'h00);
    send_word(KIND_UNUSED, 16'hA5A5, 8'h5A);
  endtask

  // Fill to capacity with extreme ids and priorities, ties and a duplicate id,
  // then push one more add that must be refused, and an unused code.
  task automatic test_fill_and_overflow();
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    for (int i = 0; i < CAPACITY; i++) begin
      id  = (i == 3) ? 16'h2222 : 16'(16'h1111 * i);
      pri = (i % 4 == 0) ? 8'hFF : (i % 4 == 1) ? 8'h00 : 8'h80;
      send_word(KIND_ADD, id, pri);
    end
    send_word(KIND_ADD, 16'h7777, 8'hFF);
    send_word(KIND_UNUSED, 16'h0000, 8'h00);
  endtask

  // Miss, duplicate-id removal, a head pop and a plain removal.
  task automatic test_remove_rules();
    send_word(KIND_REMOVE, 16'hBEEF, 8'h00);
    send_word(KIND_REMOVE, 16'h2222, 8'h00);
    send_word(KIND_POP, 16'h0000, 8'h00);
    send_word(KIND_REMOVE, 16'h5555, 8'hFF);
  endtask

  // One random word, mostly well formed: removes usually name a held id, and
  // priorities and ids often come from small pools to force ties and duplicates.
  task automatic send_random_word();
    int               roll;
    logic [KIND_W-1:0] k;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    if (burst_left == 0) begin
      fill_mode  = ~fill_mode;
      burst_left = $urandom_range(30, 8);
    end
    burst_left--;
    roll = $urandom_range(99);
    if (roll < 5) k = KIND_UNUSED;
    else if (roll < (fill_mode ? 75 : 30)) k = KIND_ADD;
    else if (roll < (fill_mode ? 88 : 65)) k = KIND_POP;
    else k = KIND_REMOVE;
    id  = ($urandom_range(99) < 30) ? ID_W'($urandom_range(7)) : ID_W'($urandom);
    pri = PRI_W'($urandom);
    if ($urandom_range(99) < 40) begin
      case ($urandom_range(3))
        0: pri = 8'h00;
        1: pri = 8'h7F;
        2: pri = 8'h80;
        default: pri = 8'hFF;
      endcase
    end
    if (k == KIND_REMOVE && model_count > 0 && $urandom_range(99) < 75) begin
      id = model_entries[$urandom_range(model_count - 1)].id;
    end
    send_word(k, id, pri);
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the result register and the engine fill and the input stalls.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 400;
    for (int i = 0; i < 30; i++) send_random_word();
  endtask

  // A block of random traffic under one idling setting.
  task automatic test_random_mix(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_random_word();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_fill_and_overflow();
    test_remove_rules();
    test_output_backpressure();
    test_random_mix(150, 0, 0);
    test_random_mix(150, 47, 0);
    test_random_mix(150, 0, 47);
    test_random_mix(150, 28, 28);

    // Drop valid, let the receiver drain, then allow the longest operation to settle.
    in_valid       <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal finish.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
